// ===== src/ycsw_pkg.sv =====
package ycsw_pkg;

  localparam int VALUE_W = 32;
  localparam int FRAC_W = 16;
  localparam int WIDE_W = 2 * VALUE_W;
  localparam int OPND_W = VALUE_W + 1;
  localparam int CNT_W = $clog2(WIDE_W);
  localparam int IN_TDATA_W = ((5 * VALUE_W + 3 + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_W + 2 + 7) / 8) * 8;
  localparam int CFG_ADDR_W = 3;

  localparam logic signed [WIDE_W-1:0] ONE_Q = WIDE_W'(1) << FRAC_W;
  localparam logic signed [WIDE_W-1:0] ROUND_ADD = ONE_Q - WIDE_W'(1);
  // shortest rollback time that still gets a counter-rotation (1 ms)
  localparam logic signed [WIDE_W-1:0] RB_MIN_TIME = (ONE_Q + WIDE_W'(500)) / WIDE_W'(1000);
  localparam logic signed [WIDE_W-1:0] VAL_MAX = (WIDE_W'(1) << (VALUE_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] VAL_MIN = -VAL_MAX - WIDE_W'(1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CORR = 2'd1,
    PH_ROLL = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_START    = 3'd0,
    CFG_ROLLBACK = 3'd1,
    CFG_END      = 3'd2,
    CFG_RATIO    = 3'd3,
    CFG_GAIN     = 3'd4,
    CFG_DEADBAND = 3'd5,
    CFG_LIMIT    = 3'd6,
    CFG_PERIOD   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] start_position;
    logic signed [VALUE_W-1:0] rollback_position;
    logic signed [VALUE_W-1:0] end_position;
    logic signed [VALUE_W-1:0] rollback_ratio;
    logic signed [VALUE_W-1:0] speed_gain;
    logic        [VALUE_W-2:0] deadband;
    logic        [VALUE_W-2:0] error_limit;
    logic        [VALUE_W-2:0] sample_period;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] position;
    logic signed [VALUE_W-1:0] left_yaw;
    logic signed [VALUE_W-1:0] right_yaw;
    logic                      front_wall;
    logic                      left_wall;
    logic                      right_wall;
    logic signed [VALUE_W-1:0] current_speed;
    logic signed [VALUE_W-1:0] desired_speed;
  } item_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic                      start;
    alu_op_t                   op;
    logic signed [WIDE_W-1:0]  a;
    logic signed [OPND_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [WIDE_W-1:0] res;
  } alu_rsp_t;

  function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    if (v > VAL_MAX) begin
      return VAL_MAX[VALUE_W-1:0];
    end else if (v < VAL_MIN) begin
      return VAL_MIN[VALUE_W-1:0];
    end
    return v[VALUE_W-1:0];
  endfunction

endpackage

// ===== src/yaw_correction_by_side_walls.sv =====
// Yaw correction from side walls. One input beat per control tick gives one output beat
// (omega_adjust and the phase after the tick), in order. Ticks in the idle, rollback and
// finished phases go through the S_PHASE and S_EMIT states to the output register, and the
// next input beat can be taken in the first cycle with a valid output beat. A correcting tick
// runs through one shared multiply/divide unit with a radix-2 divider: one divide per
// correcting tick, three for the tick that enters rollback, or two when the rollback
// time is too short for a counter-rotation. in_tready is low while a tick is in work;
// the next tick is taken while a finished result still waits in the output register.
// The configuration port is always ready and is meant to be written only while
// the block is idle.
module yaw_correction_by_side_walls import ycsw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // position, left_yaw, right_yaw, front_wall, left_wall, right_wall, current_speed,
  // desired_speed, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // omega_adjust, phase, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [VALUE_W-1:0]     cfg_data
);

  item_t                     in_item;
  cfg_regs_t                 cfg_regs;
  alu_req_t                  alu_req;
  alu_rsp_t                  alu_rsp;
  logic signed [VALUE_W-1:0] out_omega;
  phase_t                    out_phase;

  assign in_item.position      = in_tdata[VALUE_W-1:0];
  assign in_item.left_yaw      = in_tdata[2*VALUE_W-1:VALUE_W];
  assign in_item.right_yaw     = in_tdata[3*VALUE_W-1:2*VALUE_W];
  assign in_item.front_wall    = in_tdata[3*VALUE_W];
  assign in_item.left_wall     = in_tdata[3*VALUE_W+1];
  assign in_item.right_wall    = in_tdata[3*VALUE_W+2];
  assign in_item.current_speed = in_tdata[4*VALUE_W+2:3*VALUE_W+3];
  assign in_item.desired_speed = in_tdata[5*VALUE_W+2:4*VALUE_W+3];

  assign cfg_ready = 1'b1;

  ycsw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .regs    (cfg_regs)
  );

  ycsw_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  ycsw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .cfg       (cfg_regs),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_omega (out_omega),
    .out_phase (out_phase)
  );

  assign out_tdata = {{(OUT_TDATA_W-VALUE_W-2){1'b0}}, out_phase, out_omega};

  // no new work handed to the divider while it is still iterating
  a_alu_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  a_ready_alu_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !alu_rsp.busy)
    else $error("input ready while shared unit busy");

  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat accepted while a tick is in work");

  // omega is only written once correction starts, and idle never comes back
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_phase == PH_IDLE)) |-> (out_omega == '0))
    else $error("nonzero omega in idle phase");

endmodule

// ===== src/ycsw_cfg.sv =====
module ycsw_cfg import ycsw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_ADDR_W-1:0] wr_addr,
  input  logic [VALUE_W-1:0]    wr_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.start_position    <= '0;
      regs_r.rollback_position <= '0;
      regs_r.end_position      <= '0;
      regs_r.rollback_ratio    <= '0;
      regs_r.speed_gain        <= '0;
      regs_r.deadband          <= '0;
      regs_r.error_limit       <= (VALUE_W-1)'(17153);
      regs_r.sample_period     <= (VALUE_W-1)'(66);
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_addr))
        CFG_START:    regs_r.start_position    <= wr_data;
        CFG_ROLLBACK: regs_r.rollback_position <= wr_data;
        CFG_END:      regs_r.end_position      <= wr_data;
        CFG_RATIO:    regs_r.rollback_ratio    <= wr_data;
        CFG_GAIN:     regs_r.speed_gain        <= wr_data;
        CFG_DEADBAND: regs_r.deadband          <= wr_data[VALUE_W-2:0];
        CFG_LIMIT:    regs_r.error_limit       <= wr_data[VALUE_W-2:0];
        CFG_PERIOD:   regs_r.sample_period     <= wr_data[VALUE_W-2:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// ===== src/ycsw_alu.sv =====
module ycsw_alu import ycsw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIN} astate_t;

  astate_t                   state_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [WIDE_W-1:0]         quo_r;
  logic [OPND_W-1:0]         rem_r;
  logic [OPND_W-1:0]         dvs_r;
  logic                      neg_r;
  logic                      zero_r;
  logic signed [WIDE_W-1:0]  res_r;
  logic                      done_r;

  logic signed [2*OPND_W-1:0] prod;
  logic [WIDE_W-1:0]          mag_a;
  logic [OPND_W-1:0]          mag_b;
  logic [OPND_W:0]            rem_sh;
  logic [OPND_W:0]            rem_diff;
  logic                       rem_ge;
  logic signed [WIDE_W-1:0]   sat_nxt;

  always_comb begin
    prod     = $signed(req.a[OPND_W-1:0]) * req.b;
    mag_a    = req.a[WIDE_W-1] ? -req.a : req.a;
    mag_b    = req.b[OPND_W-1] ? -req.b : req.b;
    // restoring step: one quotient bit per cycle
    rem_sh   = {rem_r, quo_r[WIDE_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    rem_ge   = rem_sh >= {1'b0, dvs_r};
    if (zero_r) begin
      sat_nxt = '0;
    end else if (neg_r) begin
      sat_nxt = (quo_r > -VAL_MIN) ? VAL_MIN : -$signed(quo_r);
    end else begin
      sat_nxt = (quo_r > VAL_MAX) ? VAL_MAX : $signed(quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        A_IDLE: begin
          done_r <= req.start && (req.op == ALU_MUL);
          if (req.start) begin
            if (req.op == ALU_MUL) begin
              res_r <= prod[WIDE_W-1:0];
            end else begin
              quo_r   <= mag_a;
              rem_r   <= '0;
              dvs_r   <= mag_b;
              neg_r   <= req.a[WIDE_W-1] ^ req.b[OPND_W-1];
              zero_r  <= (req.a == '0);
              cnt_r   <= '0;
              state_r <= A_DIV;
            end
          end
        end
        A_DIV: begin
          done_r <= 1'b0;
          rem_r  <= rem_ge ? rem_diff[OPND_W-1:0] : rem_sh[OPND_W-1:0];
          quo_r  <= {quo_r[WIDE_W-2:0], rem_ge};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(WIDE_W - 1)) begin
            state_r <= A_FIN;
          end
        end
        A_FIN: begin
          // a zero divisor leaves an all-ones quotient, which saturates by sign
          res_r   <= sat_nxt;
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.busy = (state_r != A_IDLE);
  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// ===== src/ycsw_seq.sv =====
module ycsw_seq import ycsw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  item_t                     in_item,
  input  cfg_regs_t                 cfg,
  output alu_req_t                  alu_req,
  input  alu_rsp_t                  alu_rsp,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_omega,
  output phase_t                    out_phase
);

  typedef enum logic [4:0] {
    S_IDLE, S_PHASE, S_ERR, S_DB,
    S_MUL_G, S_WAIT_G, S_DIV_V, S_WAIT_V,
    S_MUL_T, S_WAIT_T, S_STEP, S_ACC,
    S_DIV_R, S_WAIT_R, S_MUL_A, S_WAIT_A, S_DIV_A, S_WAIT_D,
    S_EMIT
  } state_t;

  state_t                    state_r;
  phase_t                    phase_r;
  logic [1:0]                walls_r;   // bit0 left, bit1 right
  logic signed [VALUE_W-1:0] angle_sum_r;
  logic signed [VALUE_W-1:0] rollback_omega_r;
  logic signed [VALUE_W-1:0] omega_hold_r;
  item_t                     item_r;
  logic signed [VALUE_W:0]   err_r;
  logic signed [WIDE_W-1:0]  tmp_r;
  logic signed [VALUE_W-1:0] step_r;
  logic signed [VALUE_W-1:0] rbt_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_omega_r;
  phase_t                    out_phase_r;

  phase_t                    phase_nxt;
  logic                      latch_walls;
  logic signed [VALUE_W+1:0] lterm, rterm, esum, esum_adj, esum_half;
  logic signed [VALUE_W:0]   err_nxt;
  logic signed [VALUE_W:0]   db, lim, dbv, db_nxt;
  logic signed [WIDE_W-1:0]  tround, tshift;
  logic signed [VALUE_W-1:0] step_nxt;
  logic signed [VALUE_W-1:0] angle_nxt;
  logic signed [VALUE_W:0]   span;

  // phase step of this tick, taken from the phase held at its start
  always_comb begin
    phase_nxt   = phase_r;
    latch_walls = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (item_r.position >= cfg.start_position) begin
          latch_walls = 1'b1;
          phase_nxt = (!item_r.front_wall && (item_r.left_wall || item_r.right_wall)) ?
                      PH_CORR : PH_DONE;
        end
      end
      PH_CORR: if (item_r.position >= cfg.rollback_position) phase_nxt = PH_ROLL;
      PH_ROLL: if (item_r.position >= cfg.end_position) phase_nxt = PH_DONE;
      default: phase_nxt = PH_DONE;
    endcase
  end

  always_comb begin
    lterm     = walls_r[0] ? (VALUE_W+2)'(item_r.left_yaw) : '0;
    rterm     = walls_r[1] ? (VALUE_W+2)'(item_r.right_yaw) : '0;
    esum      = -lterm - rterm;
    // halve toward zero when both walls are averaged
    esum_adj  = esum + $signed({{(VALUE_W+1){1'b0}}, esum[VALUE_W+1]});
    esum_half = esum_adj >>> 1;
    err_nxt   = (&walls_r) ? esum_half[VALUE_W:0] : esum[VALUE_W:0];

    db  = $signed({2'b00, cfg.deadband});
    lim = $signed({2'b00, cfg.error_limit});
    if (err_r > db) begin
      dbv = err_r - db;
    end else if (err_r < -db) begin
      dbv = err_r + db;
    end else begin
      dbv = '0;
    end
    if (dbv > lim) begin
      db_nxt = lim;
    end else if (dbv < -lim) begin
      db_nxt = -lim;
    end else begin
      db_nxt = dbv;
    end

    tround    = tmp_r + (tmp_r[WIDE_W-1] ? ROUND_ADD : '0);
    tshift    = tround >>> FRAC_W;
    step_nxt  = sat_val(tshift);
    angle_nxt = sat_val(WIDE_W'(angle_sum_r) + WIDE_W'(step_r));
    span      = (VALUE_W+1)'(cfg.end_position) - (VALUE_W+1)'(cfg.rollback_position);
  end

  always_comb begin
    alu_req = '0;
    case (state_r)
      S_MUL_G: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = WIDE_W'(cfg.speed_gain);
        alu_req.b     = err_r;
      end
      S_DIV_V: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = tmp_r;
        alu_req.b     = OPND_W'(item_r.current_speed);
      end
      S_MUL_T: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = WIDE_W'(omega_hold_r);
        alu_req.b     = $signed({2'b00, cfg.sample_period});
      end
      S_DIV_R: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = WIDE_W'(span) <<< FRAC_W;
        alu_req.b     = OPND_W'(item_r.desired_speed);
      end
      S_MUL_A: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = -WIDE_W'(angle_sum_r);
        alu_req.b     = OPND_W'(cfg.rollback_ratio);
      end
      S_DIV_A: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = tmp_r;
        alu_req.b     = OPND_W'(rbt_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      phase_r          <= PH_IDLE;
      walls_r          <= '0;
      angle_sum_r      <= '0;
      rollback_omega_r <= '0;
      omega_hold_r     <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      // S_EMIT handles the output register itself
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_item;
            state_r <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (latch_walls) begin
            walls_r <= {item_r.right_wall, item_r.left_wall};
          end
          if (phase_r == PH_ROLL) begin
            omega_hold_r <= (phase_nxt == PH_DONE) ? '0 : rollback_omega_r;
          end
          phase_r <= phase_nxt;
          state_r <= (phase_r == PH_CORR) ? S_ERR : S_EMIT;
        end
        S_ERR: begin
          err_r   <= err_nxt;
          state_r <= S_DB;
        end
        S_DB: begin
          err_r   <= db_nxt;
          state_r <= S_MUL_G;
        end
        S_MUL_G: state_r <= S_WAIT_G;
        S_WAIT_G: begin
          if (alu_rsp.done) begin
            tmp_r   <= alu_rsp.res;
            state_r <= S_DIV_V;
          end
        end
        S_DIV_V: state_r <= S_WAIT_V;
        S_WAIT_V: begin
          if (alu_rsp.done) begin
            omega_hold_r <= alu_rsp.res[VALUE_W-1:0];
            state_r      <= S_MUL_T;
          end
        end
        S_MUL_T: state_r <= S_WAIT_T;
        S_WAIT_T: begin
          if (alu_rsp.done) begin
            tmp_r   <= alu_rsp.res;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          step_r  <= step_nxt;
          state_r <= S_ACC;
        end
        S_ACC: begin
          angle_sum_r <= angle_nxt;
          // phase_r already holds this tick's new phase
          state_r     <= (phase_r == PH_ROLL) ? S_DIV_R : S_EMIT;
        end
        S_DIV_R: state_r <= S_WAIT_R;
        S_WAIT_R: begin
          if (alu_rsp.done) begin
            rbt_r <= alu_rsp.res[VALUE_W-1:0];
            if (alu_rsp.res >= RB_MIN_TIME) begin
              state_r <= S_MUL_A;
            end else begin
              rollback_omega_r <= '0;
              state_r          <= S_EMIT;
            end
          end
        end
        S_MUL_A: state_r <= S_WAIT_A;
        S_WAIT_A: begin
          if (alu_rsp.done) begin
            tmp_r   <= alu_rsp.res;
            state_r <= S_DIV_A;
          end
        end
        S_DIV_A: state_r <= S_WAIT_D;
        S_WAIT_D: begin
          if (alu_rsp.done) begin
            rollback_omega_r <= alu_rsp.res[VALUE_W-1:0];
            state_r          <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_omega_r <= omega_hold_r;
            out_phase_r <= phase_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_omega = out_omega_r;
  assign out_phase = out_phase_r;

endmodule

// ===== tb/yaw_correction_by_side_walls_test.sv =====
module yaw_correction_by_side_walls_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ycsw_pkg::*;

  localparam longint Q_ONE = 64'sd65536;
  localparam longint V_MAX = 64'sd2147483647;
  localparam longint V_MIN = -V_MAX - 64'sd1;
  localparam longint RB_MIN_T = (Q_ONE + 64'sd500) / 64'sd1000;
  localparam logic [31:0] START_POS = 32'h0001_0000;
  localparam logic [31:0] RB_POS = 32'h4000_0000;

  typedef struct {
    logic [31:0] omega;
    phase_t      phase;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [VALUE_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  longint cfg_start = 0, cfg_rollback = 0, cfg_end = 0, cfg_ratio = 0, cfg_gain = 0;
  longint cfg_dband = 0, cfg_limit = 17153, cfg_period = 66;
  // predictor copy of the block state
  phase_t ph_now = PH_IDLE;
  logic lat_left = 1'b0, lat_right = 1'b0;
  longint angle_sum = 0, rb_omega = 0, omega_hold = 0;

  item_t tick_q[$];
  item_t held_tick;
  tick_result_t omega_due_q[$];
  int ticks_pushed = 0, ticks_taken = 0, results_seen = 0;
  int mismatches = 0, cfg_writes = 0;
  int phase_ticks[4] = '{0, 0, 0, 0};
  logic hold_req = 1'b0, sink_hold = 1'b0;

  yaw_correction_by_side_walls DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > V_MAX) return V_MAX;
    if (v < V_MIN) return V_MIN;
    return v;
  endfunction

  // truncating quotient; a zero divisor saturates by the sign of the dividend
  function automatic longint div_sat(input longint num, input longint den);
    if (den == 0) return (num > 0) ? V_MAX : (num < 0) ? V_MIN : 64'sd0;
    return clamp32(num / den);
  endfunction

  function automatic tick_result_t advance_yaw_model(input item_t t);
    tick_result_t r;
    phase_t nxt;
    longint pos, err, omg, step_v, rb_time;
    pos = sx(t.position);
    nxt = ph_now;
    phase_ticks[ph_now]++;
    case (ph_now)
      PH_IDLE: begin
        if (pos >= cfg_start) begin
          lat_left = t.left_wall;
          lat_right = t.right_wall;
          nxt = (!t.front_wall && (t.left_wall || t.right_wall)) ? PH_CORR : PH_DONE;
        end
      end
      PH_CORR: if (pos >= cfg_rollback) nxt = PH_ROLL;
      PH_ROLL: if (pos >= cfg_end) nxt = PH_DONE;
      default: nxt = PH_DONE;
    endcase

    if (ph_now == PH_CORR) begin
      err = 0;
      if (lat_left) err -= sx(t.left_yaw);
      if (lat_right) err -= sx(t.right_yaw);
      if (lat_left && lat_right) err /= 2;
      if (err > cfg_dband) err -= cfg_dband;
      else if (err < -cfg_dband) err += cfg_dband;
      else err = 0;
      if (err > cfg_limit) err = cfg_limit;
      else if (err < -cfg_limit) err = -cfg_limit;
      omg = div_sat(cfg_gain * err, sx(t.current_speed));
      omega_hold = omg;
      step_v = clamp32((omg * cfg_period) / Q_ONE);
      angle_sum = clamp32(angle_sum + step_v);
      if (nxt == PH_ROLL) begin
        rb_time = div_sat((cfg_end - cfg_rollback) * Q_ONE, sx(t.desired_speed));
        rb_omega = (rb_time >= RB_MIN_T) ? div_sat((-angle_sum) * cfg_ratio, rb_time) : 0;
      end
    end else if (ph_now == PH_ROLL) begin
      omega_hold = (nxt == PH_DONE) ? 0 : rb_omega;
    end

    ph_now = nxt;
    r.omega = omega_hold[31:0];
    r.phase = ph_now;
    return r;
  endfunction

  function automatic logic [31:0] rnd_val(input int mag);
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return $urandom;
      default: return 32'(int'($urandom_range(2 * mag)) - mag);
    endcase
  endfunction

  task automatic push_tick(input logic [31:0] pos, ly, ry, input logic fw, lw, rw,
                           input logic [31:0] vc, vd);
    item_t t;
    t.position = pos;
    t.left_yaw = ly;
    t.right_yaw = ry;
    t.front_wall = fw;
    t.left_wall = lw;
    t.right_wall = rw;
    t.current_speed = vc;
    t.desired_speed = vd;
    tick_q.push_back(t);
    ticks_pushed++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START:    cfg_start = sx(val);
      CFG_ROLLBACK: cfg_rollback = sx(val);
      CFG_END:      cfg_end = sx(val);
      CFG_RATIO:    cfg_ratio = sx(val);
      CFG_GAIN:     cfg_gain = sx(val);
      CFG_DEADBAND: cfg_dband = longint'({1'b0, val[30:0]});
      CFG_LIMIT:    cfg_limit = longint'({1'b0, val[30:0]});
      CFG_PERIOD:   cfg_period = longint'({1'b0, val[30:0]});
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_tuning(input logic [31:0] gain, dband, lim, period);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_DEADBAND, dband);
    write_reg(CFG_LIMIT, lim);
    write_reg(CFG_PERIOD, period);
  endtask

  task automatic wait_quiet();
    while (results_seen != ticks_pushed) @(posedge clk);
  endtask

  // random correcting ticks, positions kept below the rollback point
  task automatic corr_batch(input int n);
    logic [31:0] p;
    repeat (n) begin
      p = $urandom;
      if ($signed(p) >= $signed(RB_POS)) p[30] = 1'b0;
      push_tick(p, rnd_val(30000), rnd_val(30000), 1'($urandom), 1'($urandom),
                1'($urandom), rnd_val(1 << 17), rnd_val(1 << 17));
    end
  endtask

  task automatic loose_batch(input int n);
    repeat (n)
      push_tick(rnd_val(1 << 24), rnd_val(1 << 24), rnd_val(1 << 24), 1'($urandom),
                1'($urandom), 1'($urandom), rnd_val(1 << 24), rnd_val(1 << 24));
  endtask

  // source side
  always @(posedge clk) begin
    tick_result_t due;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due = advance_yaw_model(held_tick);
        omega_due_q.push_back(due);
        ticks_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tick_q.size() != 0 &&
            !((ticks_taken < 300 || ticks_taken >= 420) && $urandom_range(99) < 9)) begin
          held_tick = tick_q.pop_front();
          in_tdata <= IN_TDATA_W'({held_tick.desired_speed, held_tick.current_speed,
                                   held_tick.right_wall, held_tick.left_wall,
                                   held_tick.front_wall, held_tick.right_yaw,
                                   held_tick.left_yaw, held_tick.position});
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk) begin
    if (!rst_n || sink_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !((results_seen < 300 || results_seen >= 420) && $urandom_range(99) < 9);
    end
  end

  // long back-pressure window so the block fills and stalls its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (1200) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (omega_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: no result expected, got omega=%h phase=%0d",
                   results_seen, out_tdata[31:0], out_tdata[33:32]);
      end else begin
        want = omega_due_q.pop_front();
        if (out_tdata[31:0] !== want.omega || out_tdata[33:32] !== want.phase) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: omega exp %h got %h, phase exp %0d got %0d", results_seen,
                     want.omega, out_tdata[31:0], want.phase, out_tdata[33:32]);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int wall_pick;
    logic lw, rw;
    logic [31:0] span, vd, p;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // idle with reset registers: negative positions never reach start
    push_tick(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1, 1'b1,
              32'h8000_0000, 32'h7fff_ffff);
    push_tick(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0, '0, '0);
    repeat (3)
      push_tick(32'h8000_0000 | $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom),
                1'($urandom), $urandom, $urandom);
    wait_quiet();

    write_reg(CFG_START, START_POS);
    write_reg(CFG_ROLLBACK, RB_POS);
    write_reg(CFG_END, 32'h7fff_ffff);
    write_reg(CFG_RATIO, 32'h0000_8000);
    set_tuning(32'h0001_0000, 32'h0, 32'd17153, 32'd66);

    // just below start, then the latching tick
    push_tick(32'h0, $urandom, $urandom, 1'b1, 1'b0, 1'b0, $urandom, $urandom);
    push_tick(START_POS - 1, $urandom, $urandom, 1'b0, 1'b1, 1'b1, $urandom, $urandom);
    wall_pick = $urandom_range(3);
    lw = (wall_pick != 3);
    rw = (wall_pick != 2);
    push_tick(START_POS, '0, '0, 1'b0, lw, rw, 32'h0001_0000, 32'h0000_8000);

    // correcting: yaw extremes, odd halving, zero and extreme speeds
    push_tick(START_POS, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0, 32'h0001_0000, '0);
    push_tick(START_POS, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b1, 32'h0000_8000, '0);
    push_tick(START_POS, 32'd3, 32'd0, 1'b0, 1'b0, 1'b0, 32'h0001_0000, '0);
    push_tick(START_POS, -32'sd1000, -32'sd1000, 1'b0, 1'b0, 1'b0, 32'h0, '0);
    push_tick(START_POS, 32'sd1000, 32'sd1000, 1'b0, 1'b0, 1'b0, 32'h0, '0);
    push_tick(START_POS, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0, '0);
    push_tick(START_POS, 32'sd5000, 32'sd5000, 1'b0, 1'b0, 1'b0, 32'hffff_ffff, '0);
    push_tick(START_POS, -32'sd5000, -32'sd5000, 1'b0, 1'b0, 1'b0, 32'h8000_0000, '0);
    corr_batch(110);
    wait_quiet();

    // deadband edges, no clamp; the sink holds off for a long stretch in this batch
    write_reg(CFG_START, 32'h8000_0000);
    set_tuning(32'h0000_c000, 32'h0000_1000, 32'h7fff_ffff, 32'h7fff_ffff);
    push_tick(START_POS, -32'sh1000, -32'sh1000, 1'b0, 1'b0, 1'b0, 32'h0001_0000, '0);
    push_tick(START_POS, -32'sh1001, -32'sh1001, 1'b0, 1'b0, 1'b0, 32'h0001_0000, '0);
    push_tick(START_POS, 32'sh1000, 32'sh1000, 1'b0, 1'b0, 1'b0, 32'h0001_0000, '0);
    push_tick(START_POS, 32'sh1001, 32'sh1001, 1'b0, 1'b0, 1'b0, 32'h0001_0000, '0);
    corr_batch(110);
    hold_req = 1'b1;
    wait_quiet();

    write_reg(CFG_ROLLBACK, 32'h7fff_ffff);
    write_reg(CFG_RATIO, 32'h7fff_ffff);
    set_tuning(32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'hffff_ffff);
    corr_batch(110);
    wait_quiet();

    write_reg(CFG_RATIO, 32'h8000_0000);
    set_tuning(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    corr_batch(50);
    wait_quiet();

    write_reg(CFG_ROLLBACK, RB_POS);
    repeat (2) begin
      set_tuning(rnd_val(1 << 18), $urandom_range(4000), $urandom_range(1 << 16),
                 $urandom_range(1 << 12));
      corr_batch(110);
      wait_quiet();
    end

    // entry into rollback: normal, too short, zero desired speed, end before rollback
    case ($urandom_range(3))
      0: begin span = 32'h0002_0000; vd = 32'h0000_8000 + $urandom_range(32'h8000); end
      1: begin span = 32'd1; vd = 32'h7fff_ffff; end
      2: begin span = 32'h0001_0000; vd = 32'h0; end
      default: begin span = -32'sh0001_0000; vd = rnd_val(1 << 17); end
    endcase
    write_reg(CFG_END, RB_POS + span);
    write_reg(CFG_RATIO, ($urandom_range(1)) ? 32'h0000_8000 : rnd_val(1 << 17));
    push_tick(RB_POS, rnd_val(30000), rnd_val(30000), 1'b0, 1'b1, 1'b1, rnd_val(1 << 17), vd);
    if ($signed(span) > 0) begin
      repeat (8) begin
        p = RB_POS + $urandom_range(span - 1);
        push_tick(p, $urandom, $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                  $urandom, $urandom);
      end
    end
    push_tick(RB_POS + span + $urandom_range(16'hffff), $urandom, $urandom, 1'b0, 1'b0,
              1'b0, $urandom, $urandom);
    loose_batch(40);
    push_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1, 1'b1,
              32'h7fff_ffff, 32'h8000_0000);
    wait_quiet();

    // finished is sticky, whatever the registers say
    write_reg(CFG_START, 32'h7fff_ffff);
    write_reg(CFG_ROLLBACK, 32'h8000_0000);
    write_reg(CFG_END, 32'h8000_0000);
    write_reg(CFG_RATIO, $urandom);
    set_tuning($urandom, $urandom, $urandom, $urandom);
    loose_batch(20);
    wait_quiet();
    repeat (20) @(posedge clk);

    $display("%0d tick results checked: %0d idle, %0d correcting, %0d rolling back, %0d finished",
             results_seen, phase_ticks[PH_IDLE], phase_ticks[PH_CORR], phase_ticks[PH_ROLL],
             phase_ticks[PH_DONE]);
    $display("%0d register writes, walls latched left=%0b right=%0b, %0d mismatches",
             cfg_writes, lat_left, lat_right, mismatches);
    if (mismatches == 0 && omega_due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ycsw_pkg.sv
src/ycsw_cfg.sv
src/ycsw_alu.sv
src/ycsw_seq.sv
src/yaw_correction_by_side_walls.sv
tb/yaw_correction_by_side_walls_test.sv
